// ===== hdl/bcoc_pkg.sv =====
package bcoc_pkg;

   localparam int ANGLE_WIDTH    = 9;
   localparam int DISTANCE_WIDTH = 14;
   localparam int COOLDOWN_WIDTH = 16;
   localparam int COUNT_WIDTH    = 8;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [DISTANCE_WIDTH-1:0] TRIGGER_DISTANCE_RESET = 14'd2000;
   localparam logic [ANGLE_WIDTH-1:0]    ENTRY_LINE_ANGLE_RESET = 9'd90;
   localparam logic [ANGLE_WIDTH-1:0]    EXIT_LINE_ANGLE_RESET  = 9'd270;
   localparam logic [ANGLE_WIDTH-1:0]    ANGLE_WINDOW_RESET     = 9'd5;
   localparam logic [COOLDOWN_WIDTH-1:0] COOLDOWN_SECONDS_RESET = 16'd2;
   localparam logic [COUNT_WIDTH-1:0]    MAX_SPOTS_RESET        = 8'd100;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      EVENT_NONE  = 2'd0,
      EVENT_ENTER = 2'd1,
      EVENT_EXIT  = 2'd2
   } change_kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TRIGGER_DISTANCE = 3'd0,
      CSR_ENTRY_LINE_ANGLE = 3'd1,
      CSR_EXIT_LINE_ANGLE  = 3'd2,
      CSR_ANGLE_WINDOW     = 3'd3,
      CSR_COOLDOWN_SECONDS = 3'd4,
      CSR_MAX_SPOTS        = 3'd5
   } csr_index_type;

   typedef struct packed {
      command_type               command;
      logic [ANGLE_WIDTH-1:0]    angle;
      logic [DISTANCE_WIDTH-1:0] distance;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] occupancy;
      logic                   entered;
      logic                   exited;
      change_kind_type        last_change;
   } rsp_payload_type;

   // per-line window decision handed to the count update
   typedef struct packed {
      logic hit;      // sample angle inside the window
      logic first;    // window was not active before this sample
      logic qualify;  // first hit with cooldown elapsed
   } line_status_type;

endpackage

// ===== hdl/beam_crossing_occupancy_counter_unit.sv =====
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_data  (req_payload_type)
// rsp     | out       | rsp_valid / rsp_ready | rsp_data  (rsp_payload_type)
// csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One item per cycle sustained while rsp_ready holds; after the req transfer an item passes
// the input register, then window compare and count update into the result register.
// Reset is synchronous and restores register defaults and clears count, flags and timers.
// A stalled rsp holds its item; req_ready drops while the input register holds an item that cannot advance.
// csr_ready is always high; writes go straight into the configuration registers.
module beam_crossing_occupancy_counter_unit
   import bcoc_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_payload_type            rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // configuration
   logic [DISTANCE_WIDTH-1:0] trigger_distance_ff;
   logic [ANGLE_WIDTH-1:0]    entry_line_angle_ff;
   logic [ANGLE_WIDTH-1:0]    exit_line_angle_ff;
   logic [ANGLE_WIDTH-1:0]    angle_window_ff;
   logic [COOLDOWN_WIDTH-1:0] cooldown_seconds_ff;
   logic [COUNT_WIDTH-1:0]    max_spots_ff;

   // pipeline
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic            advance;

   // counter state
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   entry_win_ff, entry_win_in;
   logic                   exit_win_ff, exit_win_in;
   logic [TIMER_WIDTH-1:0] entry_since_ff, entry_since_in;
   logic [TIMER_WIDTH-1:0] exit_since_ff, exit_since_in;
   change_kind_type        last_kind_ff, last_kind_in;

   line_status_type entry_status;
   line_status_type exit_status;
   logic            sample_valid;
   logic            entered;
   logic            exited;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_distance_ff <= TRIGGER_DISTANCE_RESET;
         entry_line_angle_ff <= ENTRY_LINE_ANGLE_RESET;
         exit_line_angle_ff  <= EXIT_LINE_ANGLE_RESET;
         angle_window_ff     <= ANGLE_WINDOW_RESET;
         cooldown_seconds_ff <= COOLDOWN_SECONDS_RESET;
         max_spots_ff        <= MAX_SPOTS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRIGGER_DISTANCE: trigger_distance_ff <= csr_wdata[DISTANCE_WIDTH-1:0];
            CSR_ENTRY_LINE_ANGLE: entry_line_angle_ff <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_EXIT_LINE_ANGLE:  exit_line_angle_ff  <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_ANGLE_WINDOW:     angle_window_ff     <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_COOLDOWN_SECONDS: cooldown_seconds_ff <= csr_wdata[COOLDOWN_WIDTH-1:0];
            CSR_MAX_SPOTS:        max_spots_ff        <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   bcoc_line_detect #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_entry (
      .angle         (in_data_ff.angle),
      .line_angle    (entry_line_angle_ff),
      .window        (angle_window_ff),
      .in_window     (entry_win_ff),
      .seconds_since (entry_since_ff),
      .cooldown      (cooldown_seconds_ff),
      .status        (entry_status)
   );

   bcoc_line_detect #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_exit (
      .angle         (in_data_ff.angle),
      .line_angle    (exit_line_angle_ff),
      .window        (angle_window_ff),
      .in_window     (exit_win_ff),
      .seconds_since (exit_since_ff),
      .cooldown      (cooldown_seconds_ff),
      .status        (exit_status)
   );

   assign sample_valid = (in_data_ff.distance != '0) &&
                         (in_data_ff.distance <= trigger_distance_ff);

   always_comb begin
      count_in       = count_ff;
      entry_win_in   = entry_win_ff;
      exit_win_in    = exit_win_ff;
      entry_since_in = entry_since_ff;
      exit_since_in  = exit_since_ff;
      last_kind_in   = last_kind_ff;
      entered        = 1'b0;
      exited         = 1'b0;
      if (advance) begin
         if (in_data_ff.command == CMD_TICK) begin
            if (entry_since_ff != '1) begin
               entry_since_in = entry_since_ff + 1'b1;
            end
            if (exit_since_ff != '1) begin
               exit_since_in = exit_since_ff + 1'b1;
            end
         end else if (sample_valid) begin
            // entry first; exit sees the count after entry
            if (entry_status.hit) begin
               if (entry_status.first) begin
                  if (entry_status.qualify) begin
                     if (count_in < max_spots_ff) begin
                        count_in     = count_in + 1'b1;
                        last_kind_in = EVENT_ENTER;
                        entered      = 1'b1;
                     end
                     entry_since_in = '0;
                  end
                  entry_win_in = 1'b1;
               end
            end else begin
               entry_win_in = 1'b0;
            end

            if (exit_status.hit) begin
               if (exit_status.first) begin
                  if (exit_status.qualify) begin
                     if (count_in != '0) begin
                        count_in     = count_in - 1'b1;
                        last_kind_in = EVENT_EXIT;
                        exited       = 1'b1;
                     end
                     exit_since_in = '0;
                  end
                  exit_win_in = 1'b1;
               end
            end else begin
               exit_win_in = 1'b0;
            end
         end
      end
      rsp_data_in.occupancy   = count_in;
      rsp_data_in.entered     = entered;
      rsp_data_in.exited      = exited;
      rsp_data_in.last_change = last_kind_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         entry_win_ff   <= 1'b0;
         exit_win_ff    <= 1'b0;
         entry_since_ff <= '0;
         exit_since_ff  <= '0;
         last_kind_ff   <= EVENT_NONE;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         count_ff       <= count_in;
         entry_win_ff   <= entry_win_in;
         exit_win_ff    <= exit_win_in;
         entry_since_ff <= entry_since_in;
         exit_since_ff  <= exit_since_in;
         last_kind_ff   <= last_kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== hdl/bcoc_line_detect.sv =====
module bcoc_line_detect
   import bcoc_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  logic [ANGLE_WIDTH-1:0]    angle,
   input  logic [ANGLE_WIDTH-1:0]    line_angle,
   input  logic [ANGLE_WIDTH-1:0]    window,
   input  logic                      in_window,
   input  logic [TIMER_WIDTH-1:0]    seconds_since,
   input  logic [COOLDOWN_WIDTH-1:0] cooldown,
   output line_status_type           status
);

   localparam int CmpWidth = (TIMER_WIDTH > COOLDOWN_WIDTH) ? TIMER_WIDTH : COOLDOWN_WIDTH;

   logic [ANGLE_WIDTH-1:0] diff;
   logic                   cooled;

   // plain distance between angles, no wrap at 360
   assign diff   = (angle >= line_angle) ? (angle - line_angle) : (line_angle - angle);
   assign cooled = CmpWidth'(seconds_since) >= CmpWidth'(cooldown);

   always_comb begin
      status.hit     = diff < window;
      status.first   = status.hit && !in_window;
      status.qualify = status.first && cooled;
   end

endmodule

// ===== hdl/bcoc_checker.sv =====
module bcoc_checker
   import bcoc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // nothing comes out the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp changed");

   a_exit_marks_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.exited |-> rsp_data.last_change == EVENT_EXIT)
      else $error("exit not reported as last change");

   a_enter_marks_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entered && !rsp_data.exited
         |-> rsp_data.last_change == EVENT_ENTER)
      else $error("entry not reported as last change");

   a_enter_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entered && !rsp_data.exited |-> rsp_data.occupancy != '0)
      else $error("entry left occupancy at zero");

endmodule

bind beam_crossing_occupancy_counter_unit bcoc_checker u_bcoc_checker (.*);

// ===== dv/tb_beam_crossing_occupancy_counter_unit.sv =====
`timescale 1ns / 100ps

module tb_beam_crossing_occupancy_counter_unit
   import bcoc_pkg::*;
();

   localparam int TIMER_W     = 16;
   localparam int STALL_LIMIT = 2000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_payload_type            req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_payload_type            rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   beam_crossing_occupancy_counter_unit #(
      .TIMER_WIDTH(TIMER_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // occupancy predictor: configuration copy
   logic [DISTANCE_WIDTH-1:0] cfg_trigger_mm  = TRIGGER_DISTANCE_RESET;
   logic [ANGLE_WIDTH-1:0]    cfg_entry_deg   = ENTRY_LINE_ANGLE_RESET;
   logic [ANGLE_WIDTH-1:0]    cfg_exit_deg    = EXIT_LINE_ANGLE_RESET;
   logic [ANGLE_WIDTH-1:0]    cfg_window_deg  = ANGLE_WINDOW_RESET;
   logic [COOLDOWN_WIDTH-1:0] cfg_cooldown_s  = COOLDOWN_SECONDS_RESET;
   logic [COUNT_WIDTH-1:0]    cfg_max_spots   = MAX_SPOTS_RESET;

   // occupancy predictor: state copy
   logic [COUNT_WIDTH-1:0]    st_count        = '0;
   logic                      st_entry_active = 1'b0;
   logic                      st_exit_active  = 1'b0;
   logic [TIMER_W-1:0]        st_entry_secs   = '0;
   logic [TIMER_W-1:0]        st_exit_secs    = '0;
   change_kind_type           st_last_kind    = EVENT_NONE;

   rsp_payload_type expected_occupancy[$];
   int              mismatches = 0;
   bit              no_idle    = 1'b0;
   int              req_burst  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [ANGLE_WIDTH-1:0] angle_gap(input logic [ANGLE_WIDTH-1:0] a,
                                                        input logic [ANGLE_WIDTH-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   task automatic predict_occupancy(input req_payload_type item);
      rsp_payload_type res;
      res = '0;
      if (item.command == CMD_TICK) begin
         if (st_entry_secs != {TIMER_W{1'b1}}) st_entry_secs++;
         if (st_exit_secs != {TIMER_W{1'b1}}) st_exit_secs++;
      end else if (item.distance != '0 && item.distance <= cfg_trigger_mm) begin
         if (angle_gap(item.angle, cfg_entry_deg) < cfg_window_deg) begin
            if (!st_entry_active) begin
               if (st_entry_secs >= cfg_cooldown_s) begin
                  if (st_count < cfg_max_spots) begin
                     st_count++;
                     st_last_kind = EVENT_ENTER;
                     res.entered  = 1'b1;
                  end
                  // cooldown restarts even if saturated
                  st_entry_secs = '0;
               end
               st_entry_active = 1'b1;
            end
         end else begin
            st_entry_active = 1'b0;
         end
         if (angle_gap(item.angle, cfg_exit_deg) < cfg_window_deg) begin
            if (!st_exit_active) begin
               if (st_exit_secs >= cfg_cooldown_s) begin
                  if (st_count > 0) begin
                     st_count--;
                     st_last_kind = EVENT_EXIT;
                     res.exited   = 1'b1;
                  end
                  st_exit_secs = '0;
               end
               st_exit_active = 1'b1;
            end
         end else begin
            st_exit_active = 1'b0;
         end
      end
      res.occupancy   = st_count;
      res.last_change = st_last_kind;
      expected_occupancy.push_back(res);
   endtask

   function automatic int next_req_gap();
      int r;
      if (no_idle) return 0;
      if (req_burst > 0) begin
         req_burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         req_burst = $urandom_range(30, 150);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // entered right after the previous transfer edge; valid is held, replaced or lowered for a gap at the
   // next falling edge, never lowered and raised in one step
   task automatic send_item(input req_payload_type item);
      int gap;
      gap = next_req_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_occupancy(item);
   endtask

   task automatic send_sample(input int angle_deg, input int dist_mm);
      req_payload_type item;
      item.command  = CMD_SAMPLE;
      item.angle    = 9'(angle_deg);
      item.distance = 14'(dist_mm);
      send_item(item);
   endtask

   task automatic send_tick(input int angle_deg, input int dist_mm);
      req_payload_type item;
      item.command  = CMD_TICK;
      item.angle    = 9'(angle_deg);
      item.distance = 14'(dist_mm);
      send_item(item);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_occupancy.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TRIGGER_DISTANCE: cfg_trigger_mm = value[DISTANCE_WIDTH-1:0];
         CSR_ENTRY_LINE_ANGLE: cfg_entry_deg  = value[ANGLE_WIDTH-1:0];
         CSR_EXIT_LINE_ANGLE:  cfg_exit_deg   = value[ANGLE_WIDTH-1:0];
         CSR_ANGLE_WINDOW:     cfg_window_deg = value[ANGLE_WIDTH-1:0];
         CSR_COOLDOWN_SECONDS: cfg_cooldown_s = value[COOLDOWN_WIDTH-1:0];
         CSR_MAX_SPOTS:        cfg_max_spots  = value[COUNT_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int trig, input int entry_deg, input int exit_deg,
                             input int win, input int cool, input int spots);
      wait_for_idle();
      csr_write(CSR_TRIGGER_DISTANCE, 16'(trig));
      csr_write(CSR_ENTRY_LINE_ANGLE, 16'(entry_deg));
      csr_write(CSR_EXIT_LINE_ANGLE, 16'(exit_deg));
      csr_write(CSR_ANGLE_WINDOW, 16'(win));
      csr_write(CSR_COOLDOWN_SECONDS, 16'(cool));
      csr_write(CSR_MAX_SPOTS, 16'(spots));
   endtask

   // reset defaults: lines at 90/270, window 5, cooldown 2, trigger 2000
   task automatic test_directed_basics();
      send_tick(511, 16383);
      send_sample(90, 0);        // no return
      send_sample(90, 2001);     // beyond trigger
      send_sample(90, 2000);     // edge inside cooldown
      send_sample(0, 1);
      send_tick(0, 0);
      send_tick(256, 8192);
      send_sample(86, 100);      // just inside the window -> enter
      send_sample(94, 100);      // still in window, no edge
      send_sample(95, 100);      // on the strict boundary, clears
      send_sample(90, 100);      // cooldown restarted by the enter
      send_sample(270, 500);     // exit
      send_sample(275, 500);
      send_tick(1, 1);
      send_tick(2, 2);
      send_sample(270, 500);     // exit at zero count, timer still restarts
      send_sample(511, 16383);
      send_sample(360, 1);
      send_sample(300, 1999);
   endtask

   task automatic test_config_extremes();
      // one sample in both windows: enter then exit
      set_config(16383, 0, 359, 360, 0, 255);
      send_sample(0, 16383);
      send_sample(511, 16383);
      send_sample(0, 16383);
      send_sample(359, 1);
      send_sample(511, 8191);
      send_sample(0, 1);
      // zero window matches nothing
      set_config(16383, 0, 359, 0, 0, 255);
      send_sample(0, 5);
      send_sample(359, 5);
      // no room at all
      set_config(16383, 0, 359, 360, 0, 0);
      send_sample(100, 5);
      send_sample(500, 5);
      send_sample(100, 5);
      // zero trigger ignores every sample
      set_config(0, 0, 359, 360, 0, 255);
      send_sample(0, 1);
      send_sample(359, 16383);
   endtask

   task automatic test_count_limits();
      set_config(2000, 10, 200, 3, 0, 255);
      repeat (256) begin
         send_sample(10, 50);
         send_sample(100, 50);
      end
      // count now above the limit: enters stop, exits still work
      set_config(2000, 10, 200, 3, 0, 3);
      repeat (3) begin
         send_sample(12, 50);
         send_sample(100, 50);
      end
      repeat (257) begin
         send_sample(200, 50);
         send_sample(100, 50);
      end
   endtask

   task automatic test_long_cooldown();
      set_config(2000, 90, 270, 5, 65535, 100);
      send_sample(180, 10);
      send_sample(90, 10);
      send_sample(180, 10);
      no_idle = 1'b1;
      repeat (40) send_tick($urandom_range(0, 511), $urandom_range(0, 16383));
      no_idle = 1'b0;
      send_sample(90, 10);       // far below the largest cooldown
      send_sample(180, 10);
      set_config(2000, 90, 270, 5, 30, 100);
      send_sample(90, 10);       // cooldown now elapsed
      send_sample(270, 10);
      send_sample(180, 10);
      send_sample(90, 10);
      send_sample(270, 10);
   endtask

   task automatic test_random_traffic();
      int r;
      int trig, ent, ext, win, cool, spots;
      int line_deg, spread, a, d;
      for (int phase = 0; phase < 8; phase++) begin
         r = $urandom_range(0, 99);
         trig = (r < 10) ? 16383 : (r < 14) ? 0 : $urandom_range(200, 16383);
         r = $urandom_range(0, 99);
         ent = (r < 10) ? 0 : (r < 20) ? 359 : $urandom_range(0, 359);
         r = $urandom_range(0, 99);
         ext = (r < 10) ? 0 : (r < 20) ? 359 : (r < 30) ? ent : $urandom_range(0, 359);
         r = $urandom_range(0, 99);
         win = (r < 5) ? 0 : (r < 12) ? 360 : (r < 20) ? $urandom_range(0, 360)
                                                       : $urandom_range(1, 20);
         r = $urandom_range(0, 99);
         cool = (r < 8) ? 65535 : (r < 15) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
         r = $urandom_range(0, 99);
         spots = (r < 10) ? 0 : (r < 25) ? 255 : $urandom_range(1, 254);
         set_config(trig, ent, ext, win, cool, spots);
         repeat (55) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
               send_tick($urandom_range(0, 511), $urandom_range(0, 16383));
            end else begin
               r = $urandom_range(0, 99);
               if (r < 75)      d = $urandom_range(1, (trig == 0) ? 1 : trig);
               else if (r < 85) d = 0;
               else if (r < 95) d = $urandom_range((trig >= 16383) ? 16383 : trig + 1, 16383);
               else             d = $urandom_range(0, 16383);
               r = $urandom_range(0, 99);
               if (r < 10) begin
                  a = $urandom_range(0, 511);
               end else begin
                  line_deg = (r < 50) ? ent : (r < 90) ? ext : $urandom_range(0, 359);
                  spread   = (win > 30) ? 32 : win + 2;
                  a = line_deg + int'($urandom_range(0, 2 * spread)) - spread;
                  if (a < 0) a = 0;
                  if (a > 511) a = 511;
               end
               send_sample(a, d);
            end
         end
      end
   endtask

   initial begin : rsp_ready_driver
      int hold;
      int r;
      rsp_ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            rsp_ready <= 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_ready <= 1'b1;
               hold = $urandom_range(0, 15);
            end else if (r < 65) begin
               rsp_ready <= 1'b1;
               hold = $urandom_range(50, 200);
            end else if (r < 95) begin
               rsp_ready <= 1'b0;
               hold = $urandom_range(0, 3);
            end else begin
               rsp_ready <= 1'b0;
               hold = $urandom_range(10, 60);
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_checker
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_occupancy.size() == 0) begin
            $error("rsp transfer with no expected result");
            mismatches++;
         end else begin
            want = expected_occupancy.pop_front();
            if (rsp_data.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_data.occupancy);
               mismatches++;
            end
            if (rsp_data.entered !== want.entered) begin
               $error("entered: expected %0d, got %0d", want.entered, rsp_data.entered);
               mismatches++;
            end
            if (rsp_data.exited !== want.exited) begin
               $error("exited: expected %0d, got %0d", want.exited, rsp_data.exited);
               mismatches++;
            end
            if (rsp_data.last_change !== want.last_change) begin
               $error("last_change: expected %0d, got %0d", want.last_change,
                      rsp_data.last_change);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_beam_crossing_occupancy_counter_unit failed");
      $finish;
   end

   initial begin : stimulus
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_config_extremes();
      test_count_limits();
      test_long_cooldown();
      test_random_traffic();

      wait_for_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_occupancy.size() == 0)
         $display("tb_beam_crossing_occupancy_counter_unit passed");
      else
         $display("tb_beam_crossing_occupancy_counter_unit failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bcoc_pkg.sv
hdl/bcoc_line_detect.sv
hdl/beam_crossing_occupancy_counter_unit.sv
hdl/bcoc_checker.sv
dv/tb_beam_crossing_occupancy_counter_unit.sv
